/* rtl/mlh_pkg.sv */
package mlh_pkg;

  localparam int unsigned CounterWidthDefault = 17;
  localparam int unsigned RegWidth            = 16;
  localparam int unsigned QueueDepth          = 4;
  localparam int unsigned MaxResults          = 3;

  // register indexes
  localparam logic [2:0] REG_HB_EARLY   = 3'd0;
  localparam logic [2:0] REG_HB_LINKED  = 3'd1;
  localparam logic [2:0] REG_STATUS_PER = 3'd2;
  localparam logic [2:0] REG_QUERY_DLY  = 3'd3;
  localparam logic [2:0] REG_TIME_GAP   = 3'd4;

  localparam logic [RegWidth-1:0] HB_EARLY_RST   = 16'd3000;
  localparam logic [RegWidth-1:0] HB_LINKED_RST  = 16'd15000;
  localparam logic [RegWidth-1:0] STATUS_PER_RST = 16'd30000;
  localparam logic [RegWidth-1:0] QUERY_DLY_RST  = 16'd15000;
  localparam logic [RegWidth-1:0] TIME_GAP_RST   = 16'd500;

  // input operation
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  // received commands
  localparam logic [7:0] CMD_HELLO    = 8'h00;
  localparam logic [7:0] CMD_PRODUCT  = 8'h01;
  localparam logic [7:0] CMD_MODE     = 8'h02;
  localparam logic [7:0] CMD_QUERY    = 8'h03;
  localparam logic [7:0] CMD_RESET_A  = 8'h04;
  localparam logic [7:0] CMD_RESET_B  = 8'h05;
  localparam logic [7:0] CMD_LINKED   = 8'h07;
  localparam logic [7:0] CMD_TIME     = 8'h0E;

  // frame kinds
  localparam logic [2:0] KIND_HEARTBEAT   = 3'd0;
  localparam logic [2:0] KIND_QUERY       = 3'd1;
  localparam logic [2:0] KIND_ACK_PRODUCT = 3'd2;
  localparam logic [2:0] KIND_ACK_MODE    = 3'd3;
  localparam logic [2:0] KIND_STATUS      = 3'd4;
  localparam logic [2:0] KIND_TIME        = 3'd5;
  localparam logic [2:0] KIND_REBOOT      = 3'd6;

  // status bytes
  localparam logic [2:0] LINK_NONE  = 3'd0;
  localparam logic [2:0] LINK_RESET = 3'd1;
  localparam logic [2:0] LINK_DOWN  = 3'd2;
  localparam logic [2:0] LINK_UP    = 3'd4;

  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_HELLO  = 2'd1;
  localparam logic [1:0] PHASE_PROD   = 2'd2;
  localparam logic [1:0] PHASE_LINKED = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] link;
  } res_t;

  // results caused by one item, slot 0 first
  typedef struct packed {
    logic [1:0] cnt;
    res_t [MaxResults-1:0] r;
  } bundle_t;

endpackage

/* rtl/mlh_front.sv */
module mlh_front #(
  parameter int unsigned CounterWidth = mlh_pkg::CounterWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_idx_i,
  input  logic [mlh_pkg::RegWidth-1:0]   cfg_data_i,
  input  logic                           acc_i,
  input  logic                           op_i,
  input  logic [7:0]                     cmd_i,
  input  logic                           connected_i,
  input  logic                           time_valid_i,
  output logic                           push_o,
  output mlh_pkg::bundle_t               bundle_o
);

  localparam int unsigned CW = CounterWidth;
  localparam int unsigned RW = mlh_pkg::RegWidth;

  logic [RW-1:0] hb_early_q, hb_linked_q, status_per_q, query_dly_q, time_gap_q;
  logic [1:0]    phase_q, phase_d;
  logic          queried_q, queried_d;
  logic [CW-1:0] hb_q, hb_d, st_q, st_d, boot_q, boot_d, tr_q, tr_d;
  logic [CW-1:0] hb_n, st_n, boot_n, tr_n;
  logic [CW-1:0] hb_per;
  mlh_pkg::bundle_t b;

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
    bump = (&c) ? c : c + {{(CW-1){1'b0}}, 1'b1};
  endfunction

  function automatic logic [CW-1:0] ext(input logic [RW-1:0] v);
    ext = {{(CW-RW){1'b0}}, v};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_early_q   <= mlh_pkg::HB_EARLY_RST;
      hb_linked_q  <= mlh_pkg::HB_LINKED_RST;
      status_per_q <= mlh_pkg::STATUS_PER_RST;
      query_dly_q  <= mlh_pkg::QUERY_DLY_RST;
      time_gap_q   <= mlh_pkg::TIME_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mlh_pkg::REG_HB_EARLY:   hb_early_q   <= cfg_data_i;
        mlh_pkg::REG_HB_LINKED:  hb_linked_q  <= cfg_data_i;
        mlh_pkg::REG_STATUS_PER: status_per_q <= cfg_data_i;
        mlh_pkg::REG_QUERY_DLY:  query_dly_q  <= cfg_data_i;
        mlh_pkg::REG_TIME_GAP:   time_gap_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign hb_n   = bump(hb_q);
  assign st_n   = bump(st_q);
  assign boot_n = bump(boot_q);
  assign tr_n   = bump(tr_q);
  assign hb_per = (phase_q == mlh_pkg::PHASE_LINKED) ? ext(hb_linked_q) : ext(hb_early_q);

  always_comb begin
    phase_d   = phase_q;
    queried_d = queried_q;
    hb_d      = hb_q;
    st_d      = st_q;
    boot_d    = boot_q;
    tr_d      = tr_q;
    b         = '0;
    if (op_i == mlh_pkg::OP_TICK) begin
      hb_d   = hb_n;
      st_d   = st_n;
      boot_d = boot_n;
      tr_d   = tr_n;
      if (hb_n >= hb_per) begin
        b.r[b.cnt] = '{kind: mlh_pkg::KIND_HEARTBEAT, link: mlh_pkg::LINK_NONE};
        b.cnt      = b.cnt + 2'd1;
        hb_d       = '0;
      end
      if (phase_q == mlh_pkg::PHASE_LINKED && st_n >= ext(status_per_q)) begin
        b.r[b.cnt] = '{kind: mlh_pkg::KIND_STATUS,
                       link: connected_i ? mlh_pkg::LINK_UP : mlh_pkg::LINK_DOWN};
        b.cnt      = b.cnt + 2'd1;
        st_d       = '0;
      end
      if (phase_q != mlh_pkg::PHASE_IDLE && !queried_q && boot_n > ext(query_dly_q)) begin
        b.r[b.cnt] = '{kind: mlh_pkg::KIND_QUERY, link: mlh_pkg::LINK_NONE};
        b.cnt      = b.cnt + 2'd1;
        queried_d  = 1'b1;
      end
    end else begin
      case (cmd_i)
        mlh_pkg::CMD_HELLO: begin
          if (phase_q != mlh_pkg::PHASE_LINKED) begin
            phase_d = mlh_pkg::PHASE_HELLO;
            b.r[0]  = '{kind: mlh_pkg::KIND_STATUS, link: mlh_pkg::LINK_UP};
            b.cnt   = 2'd1;
          end
        end
        mlh_pkg::CMD_PRODUCT: begin
          b.r[0] = '{kind: mlh_pkg::KIND_ACK_PRODUCT, link: mlh_pkg::LINK_NONE};
          b.r[1] = '{kind: mlh_pkg::KIND_STATUS, link: mlh_pkg::LINK_UP};
          b.cnt  = 2'd2;
          if (phase_q < mlh_pkg::PHASE_PROD) phase_d = mlh_pkg::PHASE_PROD;
        end
        mlh_pkg::CMD_MODE: begin
          b.r[0] = '{kind: mlh_pkg::KIND_ACK_MODE, link: mlh_pkg::LINK_NONE};
          b.cnt  = 2'd1;
        end
        mlh_pkg::CMD_QUERY: begin
          if (!queried_q) begin
            b.r[0]    = '{kind: mlh_pkg::KIND_QUERY, link: mlh_pkg::LINK_NONE};
            b.cnt     = 2'd1;
            queried_d = 1'b1;
          end
        end
        mlh_pkg::CMD_LINKED: phase_d = mlh_pkg::PHASE_LINKED;
        mlh_pkg::CMD_TIME: begin
          if (time_valid_i && tr_q > ext(time_gap_q)) begin
            b.r[0] = '{kind: mlh_pkg::KIND_TIME, link: mlh_pkg::LINK_NONE};
            b.cnt  = 2'd1;
            tr_d   = '0;
          end
        end
        mlh_pkg::CMD_RESET_A, mlh_pkg::CMD_RESET_B: begin
          b.r[0] = '{kind: mlh_pkg::KIND_STATUS, link: mlh_pkg::LINK_RESET};
          b.r[1] = '{kind: mlh_pkg::KIND_REBOOT, link: mlh_pkg::LINK_NONE};
          b.cnt  = 2'd2;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mlh_pkg::PHASE_IDLE;
      queried_q <= 1'b0;
      hb_q      <= '0;
      st_q      <= '0;
      boot_q    <= '0;
      tr_q      <= '0;
    end else if (acc_i) begin
      phase_q   <= phase_d;
      queried_q <= queried_d;
      hb_q      <= hb_d;
      st_q      <= st_d;
      boot_q    <= boot_d;
      tr_q      <= tr_d;
    end
  end

  // items that cause no result never enter the queue
  assign push_o   = acc_i && (b.cnt != 2'd0);
  assign bundle_o = b;

endmodule

/* rtl/mlh_queue.sv */
module mlh_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mlh_pkg::bundle_t data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output mlh_pkg::bundle_t data_o
);

  localparam int unsigned Depth = mlh_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  mlh_pkg::bundle_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

endmodule

/* rtl/mlh_back.sv */
module mlh_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  mlh_pkg::bundle_t head_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output mlh_pkg::res_t    res_o,
  output logic             last_o
);

  logic [1:0]    sub_q;
  logic          valid_q;
  mlh_pkg::res_t res_q;
  logic          last_q;
  logic          load, is_last;

  // output register refills whenever the queue is not empty and the register is empty or being taken
  assign load    = !empty_i && (!valid_q || ready_i);
  assign is_last = (sub_q == head_i.cnt - 2'd1);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        sub_q   <= is_last ? 2'd0 : sub_q + 2'd1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= head_i.r[sub_q];
      last_q <= is_last;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
  assign last_o  = last_q;

endmodule

/* rtl/module_link_handshake.sv */
// Serial link handshake keeper. Each input item is a 1 ms tick (tuser = 0) or a
// received command byte (tuser = 1); every item yields zero to three reply frame
// kinds, streamed one per cycle while m_axis_tready holds, tlast on the item's last.
// Items are taken one per cycle as long as the four-entry result queue between
// the classifier and the output serializer has room; an item that produces n
// results occupies the output for n frames, so a long run of multi-result items
// is paced by the single output port. Items with no result never enter the queue.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect the next
// cycle and must only be issued while the block is idle.
module module_link_handshake #(
  parameter int unsigned COUNTER_WIDTH = mlh_pkg::CounterWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] command, [8] wifi_connected, [9] time_valid
  input  logic        s_axis_tuser,  // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [2:0] frame_kind, [5:3] link_status
  output logic        m_axis_tlast
);

  logic             acc, push, full, empty, pop;
  mlh_pkg::bundle_t fb, head;
  mlh_pkg::res_t    res;

  assign s_axis_tready = !full;
  assign acc           = s_axis_tvalid && s_axis_tready;

  mlh_front #(.CounterWidth(COUNTER_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .acc_i        (acc),
    .op_i         (s_axis_tuser),
    .cmd_i        (s_axis_tdata[7:0]),
    .connected_i  (s_axis_tdata[8]),
    .time_valid_i (s_axis_tdata[9]),
    .push_o       (push),
    .bundle_o     (fb)
  );

  mlh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fb),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .data_o  (head)
  );

  mlh_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, res.link, res.kind};

endmodule

/* test/tb_module_link_handshake.sv */
`timescale 1ns / 1ps

module tb_module_link_handshake;

  localparam int unsigned CntMax      = (1 << mlh_pkg::CounterWidthDefault) - 1;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned NumScript   = 21;
  localparam int unsigned PhaseItems  = 82;

  // index with no register behind it, and command bytes with no meaning
  localparam logic [2:0] RegUnused     = 3'd7;
  localparam logic [7:0] CMD_UNUSED_HI = 8'hFF;
  localparam logic [7:0] CMD_UNUSED_LO = 8'h08;

  localparam mlh_pkg::res_t NoFrame = '0;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] link;
    logic       last;
  } frame_t;

  // one stimulus row; typed rows carry their own expected frames
  typedef struct packed {
    logic       op;
    logic [7:0] cmd;
    logic       wifi;
    logic       tv;
    logic       typed;
    logic [1:0] cnt;
    mlh_pkg::res_t [1:0] r;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [7:0] command, [8] wifi_connected, [9] time_valid
  logic        s_axis_tuser = 1'b0;  // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // [2:0] frame_kind, [5:3] link_status
  logic        m_axis_tlast;

  // link keeper shadow state
  logic [15:0] hb_early   = mlh_pkg::HB_EARLY_RST;
  logic [15:0] hb_linked  = mlh_pkg::HB_LINKED_RST;
  logic [15:0] status_per = mlh_pkg::STATUS_PER_RST;
  logic [15:0] query_dly  = mlh_pkg::QUERY_DLY_RST;
  logic [15:0] time_gap   = mlh_pkg::TIME_GAP_RST;
  logic [1:0]  hs_phase   = mlh_pkg::PHASE_IDLE;
  logic        queried_flag = 1'b0;
  int unsigned hb_ms = 0;
  int unsigned status_ms = 0;
  int unsigned boot_ms = 0;
  int unsigned time_ms = 0;

  mlh_pkg::res_t planned [3];
  frame_t      frames_due [$];
  frame_t      want_frame;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned frames_seen = 0;
  int unsigned ticks_in = 0;
  int unsigned cmds_in = 0;
  int unsigned settings = 0;

  module_link_handshake dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("unexpected frame kind %0d link %0d",
                                  m_axis_tdata[2:0], m_axis_tdata[5:3]));
      end else begin
        want_frame = frames_due.pop_front();
        if (m_axis_tdata[2:0] !== want_frame.kind)
          report_mismatch($sformatf("frame_kind %0d, want %0d",
                                    m_axis_tdata[2:0], want_frame.kind));
        if (m_axis_tdata[5:3] !== want_frame.link)
          report_mismatch($sformatf("link_status %0d, want %0d",
                                    m_axis_tdata[5:3], want_frame.link));
        if (m_axis_tlast !== want_frame.last)
          report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, want_frame.last));
        frames_seen++;
      end
    end
  end

  function automatic int unsigned sat_inc(input int unsigned c);
    return (c >= CntMax) ? c : c + 1;
  endfunction

  // Advances the shadow state by one item and leaves its reply frames in planned.
  function automatic int plan_replies(input logic op, input logic [7:0] cmd,
                                      input logic wifi, input logic tv);
    int n;
    logic [15:0] hb_due;
    n = 0;
    if (op == mlh_pkg::OP_TICK) begin
      hb_ms     = sat_inc(hb_ms);
      status_ms = sat_inc(status_ms);
      boot_ms   = sat_inc(boot_ms);
      time_ms   = sat_inc(time_ms);
      hb_due = (hs_phase == mlh_pkg::PHASE_LINKED) ? hb_linked : hb_early;
      if (hb_ms >= hb_due) begin
        planned[n] = {mlh_pkg::KIND_HEARTBEAT, mlh_pkg::LINK_NONE};
        n++;
        hb_ms = 0;
      end
      if (hs_phase == mlh_pkg::PHASE_LINKED && status_ms >= status_per) begin
        planned[n] = {mlh_pkg::KIND_STATUS, wifi ? mlh_pkg::LINK_UP : mlh_pkg::LINK_DOWN};
        n++;
        status_ms = 0;
      end
      if (hs_phase != mlh_pkg::PHASE_IDLE && !queried_flag && boot_ms > query_dly) begin
        planned[n] = {mlh_pkg::KIND_QUERY, mlh_pkg::LINK_NONE};
        n++;
        queried_flag = 1'b1;
      end
    end else begin
      case (cmd)
        mlh_pkg::CMD_HELLO: begin
          if (hs_phase != mlh_pkg::PHASE_LINKED) begin
            hs_phase = mlh_pkg::PHASE_HELLO;
            planned[n] = {mlh_pkg::KIND_STATUS, mlh_pkg::LINK_UP};
            n++;
          end
        end
        mlh_pkg::CMD_PRODUCT: begin
          planned[0] = {mlh_pkg::KIND_ACK_PRODUCT, mlh_pkg::LINK_NONE};
          planned[1] = {mlh_pkg::KIND_STATUS, mlh_pkg::LINK_UP};
          n = 2;
          if (hs_phase < mlh_pkg::PHASE_PROD) hs_phase = mlh_pkg::PHASE_PROD;
        end
        mlh_pkg::CMD_MODE: begin
          planned[n] = {mlh_pkg::KIND_ACK_MODE, mlh_pkg::LINK_NONE};
          n++;
        end
        mlh_pkg::CMD_QUERY: begin
          if (!queried_flag) begin
            planned[n] = {mlh_pkg::KIND_QUERY, mlh_pkg::LINK_NONE};
            n++;
            queried_flag = 1'b1;
          end
        end
        mlh_pkg::CMD_LINKED: hs_phase = mlh_pkg::PHASE_LINKED;
        mlh_pkg::CMD_TIME: begin
          if (tv && time_ms > time_gap) begin
            time_ms = 0;
            planned[n] = {mlh_pkg::KIND_TIME, mlh_pkg::LINK_NONE};
            n++;
          end
        end
        mlh_pkg::CMD_RESET_A, mlh_pkg::CMD_RESET_B: begin
          planned[0] = {mlh_pkg::KIND_STATUS, mlh_pkg::LINK_RESET};
          planned[1] = {mlh_pkg::KIND_REBOOT, mlh_pkg::LINK_NONE};
          n = 2;
        end
        default: ;
      endcase
    end
    return n;
  endfunction

  function automatic row_t mk(input logic op, input logic [7:0] cmd, input logic wifi,
                              input logic tv, input logic typed, input logic [1:0] cnt,
                              input mlh_pkg::res_t r0, input mlh_pkg::res_t r1);
    row_t row;
    row.op = op;
    row.cmd = cmd;
    row.wifi = wifi;
    row.tv = tv;
    row.typed = typed;
    row.cnt = cnt;
    row.r[0] = r0;
    row.r[1] = r1;
    return row;
  endfunction

  // Directed rows, run with early=2, linked=1, status=1, query delay=2, gap=0.
  function automatic row_t script_row(input int i);
    row_t row;
    row = '0;
    case (i)
      0:  row = mk(mlh_pkg::OP_FRAME, mlh_pkg::CMD_TIME, 1'b0, 1'b1, 1'b1, 2'd0,
                   NoFrame, NoFrame);
      1:  row = mk(mlh_pkg::OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 2'd0, NoFrame, NoFrame);
      2:  row = mk(mlh_pkg::OP_FRAME, mlh_pkg::CMD_TIME, 1'b0, 1'b1, 1'b1, 2'd1,
                   {mlh_pkg::KIND_TIME, mlh_pkg::LINK_NONE}, NoFrame);
      // gap of zero still needs one tick in between
      3:  row = mk(mlh_pkg::OP_FRAME, mlh_pkg::CMD_TIME, 1'b1, 1'b1, 1'b1, 2'd0,
                   NoFrame, NoFrame);
      4:  row = mk(mlh_pkg::OP_FRAME, mlh_pkg::CMD_HELLO, 1'b0, 1'b0, 1'b1, 2'd1,
                   {mlh_pkg::KIND_STATUS, mlh_pkg::LINK_UP}, NoFrame);
      5:  row = mk(mlh_pkg::OP_FRAME, mlh_pkg::CMD_PRODUCT, 1'b0, 1'b0, 1'b1, 2'd2,
                   {mlh_pkg::KIND_ACK_PRODUCT, mlh_pkg::LINK_NONE},
                   {mlh_pkg::KIND_STATUS, mlh_pkg::LINK_UP});
      // hello drops the phase back from product
      6:  row = mk(mlh_pkg::OP_FRAME, mlh_pkg::CMD_HELLO, 1'b1, 1'b0, 1'b1, 2'd1,
                   {mlh_pkg::KIND_STATUS, mlh_pkg::LINK_UP}, NoFrame);
      7:  row = mk(mlh_pkg::OP_TICK, 8'hA5, 1'b0, 1'b1, 1'b0, 2'd0, NoFrame, NoFrame);
      8:  row = mk(mlh_pkg::OP_FRAME, mlh_pkg::CMD_LINKED, 1'b0, 1'b0, 1'b1, 2'd0,
                   NoFrame, NoFrame);
      9:  row = mk(mlh_pkg::OP_FRAME, mlh_pkg::CMD_HELLO, 1'b0, 1'b0, 1'b1, 2'd0,
                   NoFrame, NoFrame);
      // heartbeat, status and fallback query from one tick
      10: row = mk(mlh_pkg::OP_TICK, 8'h5A, 1'b1, 1'b0, 1'b0, 2'd0, NoFrame, NoFrame);
      11: row = mk(mlh_pkg::OP_FRAME, mlh_pkg::CMD_QUERY, 1'b0, 1'b0, 1'b1, 2'd0,
                   NoFrame, NoFrame);
      12: row = mk(mlh_pkg::OP_TICK, 8'hFF, 1'b0, 1'b1, 1'b0, 2'd0, NoFrame, NoFrame);
      13: row = mk(mlh_pkg::OP_FRAME, mlh_pkg::CMD_PRODUCT, 1'b1, 1'b1, 1'b1, 2'd2,
                   {mlh_pkg::KIND_ACK_PRODUCT, mlh_pkg::LINK_NONE},
                   {mlh_pkg::KIND_STATUS, mlh_pkg::LINK_UP});
      14: row = mk(mlh_pkg::OP_FRAME, mlh_pkg::CMD_MODE, 1'b0, 1'b0, 1'b1, 2'd1,
                   {mlh_pkg::KIND_ACK_MODE, mlh_pkg::LINK_NONE}, NoFrame);
      15: row = mk(mlh_pkg::OP_FRAME, mlh_pkg::CMD_RESET_A, 1'b0, 1'b0, 1'b1, 2'd2,
                   {mlh_pkg::KIND_STATUS, mlh_pkg::LINK_RESET},
                   {mlh_pkg::KIND_REBOOT, mlh_pkg::LINK_NONE});
      16: row = mk(mlh_pkg::OP_FRAME, mlh_pkg::CMD_RESET_B, 1'b1, 1'b1, 1'b1, 2'd2,
                   {mlh_pkg::KIND_STATUS, mlh_pkg::LINK_RESET},
                   {mlh_pkg::KIND_REBOOT, mlh_pkg::LINK_NONE});
      17: row = mk(mlh_pkg::OP_FRAME, CMD_UNUSED_HI, 1'b1, 1'b1, 1'b1, 2'd0,
                   NoFrame, NoFrame);
      18: row = mk(mlh_pkg::OP_FRAME, mlh_pkg::CMD_TIME, 1'b1, 1'b0, 1'b1, 2'd0,
                   NoFrame, NoFrame);
      19: row = mk(mlh_pkg::OP_FRAME, mlh_pkg::CMD_TIME, 1'b0, 1'b1, 1'b0, 2'd0,
                   NoFrame, NoFrame);
      default: row = mk(mlh_pkg::OP_FRAME, CMD_UNUSED_LO, 1'b0, 1'b0, 1'b1, 2'd0,
                        NoFrame, NoFrame);
    endcase
    return row;
  endfunction

  task automatic send_item(input row_t row);
    int n;
    int i;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= row.op;
    s_axis_tdata  <= {6'd0, row.tv, row.wifi, row.cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n = plan_replies(row.op, row.cmd, row.wifi, row.tv);
    if (row.typed) begin
      n = row.cnt;
      for (i = 0; i < n; i++) planned[i] = row.r[i];
    end
    for (i = 0; i < n; i++) frames_due.insert(frames_due.size(), {planned[i], i == n - 1});
    if (row.op == mlh_pkg::OP_TICK) ticks_in++;
    else cmds_in++;
  endtask

  task automatic drain_replies(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // writes every register, then the unused index, which must change nothing
  task automatic load_regs(input logic [15:0] early, input logic [15:0] linked,
                           input logic [15:0] status, input logic [15:0] query,
                           input logic [15:0] gap);
    int i;
    logic [2:0] idx;
    logic [15:0] val;
    for (i = 0; i < 6; i++) begin
      case (i)
        0: begin idx = mlh_pkg::REG_HB_EARLY;   val = early;  end
        1: begin idx = mlh_pkg::REG_HB_LINKED;  val = linked; end
        2: begin idx = mlh_pkg::REG_STATUS_PER; val = status; end
        3: begin idx = mlh_pkg::REG_QUERY_DLY;  val = query;  end
        4: begin idx = mlh_pkg::REG_TIME_GAP;   val = gap;    end
        default: begin idx = RegUnused; val = 16'($urandom_range(65535)); end
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= val;
      @(posedge clk_i);
      case (idx)
        mlh_pkg::REG_HB_EARLY:   hb_early = val;
        mlh_pkg::REG_HB_LINKED:  hb_linked = val;
        mlh_pkg::REG_STATUS_PER: status_per = val;
        mlh_pkg::REG_QUERY_DLY:  query_dly = val;
        mlh_pkg::REG_TIME_GAP:   time_gap = val;
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic run_random(input int unsigned items, input int unsigned idle,
                            input int unsigned stall, input bit pause_midway);
    int unsigned done;
    row_t row;
    send_idle_pct = idle;
    stall_pct = stall;
    done = 0;
    while (done < items) begin
      row = '0;
      row.op = ($urandom_range(99) < 55) ? mlh_pkg::OP_TICK : mlh_pkg::OP_FRAME;
      row.wifi = 1'($urandom);
      row.tv = 1'($urandom);
      row.cmd = 8'($urandom_range(255));
      if (row.op == mlh_pkg::OP_FRAME && $urandom_range(99) < 80) begin
        case ($urandom_range(7))
          0: row.cmd = mlh_pkg::CMD_HELLO;
          1: row.cmd = mlh_pkg::CMD_PRODUCT;
          2: row.cmd = mlh_pkg::CMD_MODE;
          3: row.cmd = mlh_pkg::CMD_QUERY;
          4: row.cmd = mlh_pkg::CMD_RESET_A;
          5: row.cmd = mlh_pkg::CMD_RESET_B;
          6: row.cmd = mlh_pkg::CMD_LINKED;
          default: row.cmd = mlh_pkg::CMD_TIME;
        endcase
      end
      send_item(row);
      if (row.op == mlh_pkg::OP_TICK) begin
        done++;
      end else begin
        case (row.cmd)
          mlh_pkg::CMD_HELLO, mlh_pkg::CMD_PRODUCT, mlh_pkg::CMD_MODE,
          mlh_pkg::CMD_QUERY, mlh_pkg::CMD_RESET_A, mlh_pkg::CMD_RESET_B,
          mlh_pkg::CMD_LINKED, mlh_pkg::CMD_TIME: done++;
          default: ;
        endcase
      end
      // hold off until the output side has caught up completely
      if (pause_midway && done == items / 2) drain_replies(0);
    end
    drain_replies(DrainCycles);
  endtask

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int i;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_regs(16'd2, 16'd1, 16'd1, 16'd2, 16'd0);
    for (i = 0; i < NumScript; i++) send_item(script_row(i));
    drain_replies(DrainCycles);

    load_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
    run_random(PhaseItems, 0, 0, 1'b0);
    load_regs(16'd65535, 16'd7, 16'd13, 16'd65535, 16'd5);
    run_random(PhaseItems, 83, 0, 1'b1);
    load_regs(16'd9, 16'd65535, 16'd65535, 16'd1, 16'd65535);
    run_random(PhaseItems, 0, 83, 1'b0);
    load_regs(16'd3000, 16'd3, 16'd2, 16'd15000, 16'd3);
    run_random(PhaseItems, 24, 24, 1'b0);
    load_regs(16'd2, 16'd2, 16'd5, 16'd40000, 16'd1);
    run_random(PhaseItems, 0, 0, 1'b0);

    $display("covered %0d ms ticks and %0d received commands over %0d register settings",
             ticks_in, cmds_in, settings);
    $display("%0d reply frames compared, %0d mismatches", frames_seen, mismatches);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
